>>> rtl/adc_ssr_pkg.sv
// Package for the ADC scan supervisor and regulator.
// Holds request/response types, slot and register codes, and limits.
// No dependencies; imported by every module in rtl/.
`timescale 1ns / 1ps

package adc_ssr_pkg;

    // Field and state widths
    localparam int MODE_W   = 2;
    localparam int CHAN_W   = 4;
    localparam int SAMP_W   = 10;
    localparam int SEL_W    = 3;
    localparam int SUM_W    = 16;
    localparam int DUTY_W   = 10;
    localparam int HEAT_W   = 8;
    localparam int FAULT_W  = 4;
    localparam int ROUND_W  = 6;
    localparam int TRIP_W   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int SUM_N    = 8;
    localparam int TRIP_N   = 3;

    // Default block length and trip run length
    localparam int unsigned ROUNDS_DEF = 63;
    localparam int unsigned TRIP_DEF   = 15;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    // Scan slots
    localparam logic [CHAN_W-1:0] SLOT_TEMP   = 4'd0;
    localparam logic [CHAN_W-1:0] SLOT_HCUR   = 4'd1;
    localparam logic [CHAN_W-1:0] SLOT_HVOLT  = 4'd3;
    localparam logic [CHAN_W-1:0] SLOT_AVOLT  = 4'd5;
    localparam logic [CHAN_W-1:0] SLOT_ACUR   = 4'd7;
    localparam logic [CHAN_W-1:0] SLOT_SVOLT  = 4'd9;
    localparam logic [CHAN_W-1:0] SLOT_SCUR   = 4'd11;
    localparam logic [CHAN_W-1:0] SLOT_GRID   = 4'd13;
    localparam logic [CHAN_W-1:0] GRID_FIRST  = 4'd1;
    localparam logic [CHAN_W-1:0] GRID_LAST   = 4'd12;

    // Sum indexes
    localparam logic [SEL_W-1:0] SUM_TEMP  = 3'd0;
    localparam logic [SEL_W-1:0] SUM_HCUR  = 3'd1;
    localparam logic [SEL_W-1:0] SUM_HVOLT = 3'd2;
    localparam logic [SEL_W-1:0] SUM_AVOLT = 3'd3;
    localparam logic [SEL_W-1:0] SUM_ACUR  = 3'd4;
    localparam logic [SEL_W-1:0] SUM_SVOLT = 3'd5;
    localparam logic [SEL_W-1:0] SUM_SCUR  = 3'd6;
    localparam logic [SEL_W-1:0] SUM_GRID  = 3'd7;

    // Trip counter indexes
    localparam logic [1:0] TRIP_HEAT   = 2'd0;
    localparam logic [1:0] TRIP_ANODE  = 2'd1;
    localparam logic [1:0] TRIP_SCREEN = 2'd2;

    // Fault bits
    localparam int FLT_HEAT   = 0;
    localparam int FLT_ANODE  = 1;
    localparam int FLT_SCREEN = 2;
    localparam int FLT_TEMP   = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HV_TGT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HC_TGT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A_TGT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_S_TGT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REF      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HI_TEMP  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LO_TEMP  = 3'd7;

    // Sample limits
    localparam logic [SAMP_W-1:0] HCUR_LIMIT = 10'd400;
    localparam logic [SAMP_W-1:0] OVER_LIMIT = 10'd1020;
    localparam logic [SAMP_W-1:0] RANGE_UP   = 10'd950;
    localparam logic [SAMP_W-1:0] RANGE_DOWN = 10'd85;

    // Heater regulation
    localparam logic [SUM_W-1:0]  IH_MIN        = 16'd32;
    localparam logic [HEAT_W-1:0] HEAT_MAX      = 8'd255;
    localparam logic [HEAT_W-1:0] HEAT_LOW_STEP = 8'd8;
    // x/10 == (x*52429)>>19 exactly for x < 2^18
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;
    localparam int          PROD_W      = 32;
    localparam int          V_SHIFT     = 14;
    localparam int          CV_SHIFT    = 16;
    localparam int          CI_SHIFT    = 15;
    localparam int          DIFF_W      = PROD_W - V_SHIFT;          // 18
    localparam int          QPROD_W     = DIFF_W + 16;               // 34
    localparam int          QUO_W       = QPROD_W - DIV10_SHIFT;     // 15
    localparam int          CUR_W       = PROD_W - CI_SHIFT;         // 17

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CHAN_W-1:0] channel;
        logic [SAMP_W-1:0] sample;
        logic [SEL_W-1:0]  sum_index;
    } t_in_req;

    typedef struct packed {
        logic                grid_reset;
        logic [DUTY_W-1:0]   anode_drive;
        logic [DUTY_W-1:0]   screen_drive;
        logic [HEAT_W-1:0]   heater_drive;
        logic                high_range;
        logic [FAULT_W-1:0]  error_flags;
        logic                block_done;
        logic [SUM_W-1:0]    read_value;
    } t_out_rsp;

    // Front stage to heater pipeline
    typedef struct packed {
        t_out_rsp            rsp;
        logic [HEAT_W-1:0]   hv_tgt;
        logic [HEAT_W-1:0]   hc_tgt;
        logic [SUM_W-1:0]    uh;
        logic [SUM_W-1:0]    ih;
        logic                ih_gt_min;
    } t_stage;

endpackage

>>> rtl/adc_ssr_front.sv
// Front stage: config registers, scan sums, trip logic, drive slewing, range.
// Depends on adc_ssr_pkg.
`timescale 1ns / 1ps

module adc_ssr_front import adc_ssr_pkg::*; #(
    parameter int unsigned ROUNDS_PER_BLOCK = ROUNDS_DEF,
    parameter int unsigned TRIP_COUNT       = TRIP_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_req              i_in_req,
    output logic                 o_s1_valid,
    output t_stage               o_s1,
    input  logic                 i_s2_ready,
    output logic [SUM_W-1:0]     o_ref_scale
);

    // Config registers
    logic [SAMP_W-1:0] r_grid_thr;
    logic [HEAT_W-1:0] r_hv_tgt, n_hv_tgt;
    logic [HEAT_W-1:0] r_hc_tgt, n_hc_tgt;
    logic [DUTY_W-1:0] r_a_tgt, n_a_tgt;
    logic [DUTY_W-1:0] r_s_tgt, n_s_tgt;
    logic [SUM_W-1:0]  r_ref;
    logic [SUM_W-1:0]  r_hi_temp;
    logic [SUM_W-1:0]  r_lo_temp;

    // Scan state
    logic [SUM_W-1:0]   r_running [SUM_N];
    logic [SUM_W-1:0]   n_running [SUM_N];
    logic [SUM_W-1:0]   r_latched [SUM_N];
    logic [SUM_W-1:0]   n_latched [SUM_N];
    logic [ROUND_W-1:0] r_round, n_round;
    logic [TRIP_W-1:0]  r_trip [TRIP_N];
    logic [TRIP_W-1:0]  n_trip [TRIP_N];
    logic [DUTY_W-1:0]  r_a_duty, n_a_duty;
    logic [DUTY_W-1:0]  r_s_duty, n_s_duty;
    logic               r_range, n_range;
    logic [FAULT_W-1:0] r_fault, n_fault;

    logic   r_s1_valid;
    t_stage r_s1, n_s1;
    logic   w_accept;

    function automatic logic [DUTY_W-1:0] f_slew(input logic [DUTY_W-1:0] duty,
                                                 input logic [DUTY_W-1:0] tgt);
        logic [DUTY_W-1:0] d;
        d = duty;
        if (d < tgt)
            d = d + 1'b1;
        else if (d > tgt)
            d = d - 1'b1;
        return d;
    endfunction

    // Trip counter step: reload when in limit, count down, trip at zero
    function automatic logic [TRIP_W-1:0] f_trip_next(input logic [TRIP_W-1:0] cnt,
                                                      input logic over);
        logic [TRIP_W-1:0] c;
        c = cnt;
        if (!over)
            c = TRIP_W'(TRIP_COUNT);
        else if (cnt != '0)
            c = cnt - 1'b1;
        return c;
    endfunction

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = !r_s1_valid || i_s2_ready;

    // Single pass state update for one request
    always_comb begin
        logic [SAMP_W-1:0] smp;
        logic [SUM_W-1:0]  smp_ext;
        logic              over;
        logic              trip;
        logic              grid;
        logic              done;
        logic [SUM_W-1:0]  readv;
        logic [DUTY_W-1:0] a_base;

        smp     = i_in_req.sample;
        smp_ext = {{(SUM_W-SAMP_W){1'b0}}, smp};
        over    = 1'b0;
        trip    = 1'b0;
        grid    = 1'b0;
        done    = 1'b0;
        readv   = '0;
        a_base  = r_a_duty;

        n_hv_tgt  = r_hv_tgt;
        n_hc_tgt  = r_hc_tgt;
        n_a_tgt   = r_a_tgt;
        n_s_tgt   = r_s_tgt;
        n_running = r_running;
        n_latched = r_latched;
        n_round   = r_round;
        n_trip    = r_trip;
        n_a_duty  = r_a_duty;
        n_s_duty  = r_s_duty;
        n_range   = r_range;
        n_fault   = r_fault;

        if (w_accept) begin
            case (i_in_req.mode)
                MODE_CLEAR: begin
                    n_fault = '0;
                end
                MODE_READ: begin
                    readv = r_latched[i_in_req.sum_index];
                end
                MODE_SAMPLE: begin
                    grid = (i_in_req.channel >= GRID_FIRST) && (i_in_req.channel <= GRID_LAST)
                           && (smp >= r_grid_thr);
                    case (i_in_req.channel)
                        SLOT_TEMP: begin
                            n_running[SUM_TEMP] = r_running[SUM_TEMP] + smp_ext;
                        end
                        SLOT_HCUR: begin
                            n_running[SUM_HCUR] = r_running[SUM_HCUR] + smp_ext;
                            over = smp > HCUR_LIMIT;
                            trip = over && (r_trip[TRIP_HEAT] == '0);
                            n_trip[TRIP_HEAT] = f_trip_next(r_trip[TRIP_HEAT], over);
                            if (trip) begin
                                n_hv_tgt = '0;
                                n_hc_tgt = '0;
                                n_fault[FLT_HEAT] = 1'b1;
                            end
                        end
                        SLOT_HVOLT: begin
                            n_running[SUM_HVOLT] = r_running[SUM_HVOLT] + smp_ext;
                        end
                        SLOT_AVOLT: begin
                            n_running[SUM_AVOLT] = r_running[SUM_AVOLT] + smp_ext;
                        end
                        SLOT_ACUR: begin
                            n_running[SUM_ACUR] = r_running[SUM_ACUR] + smp_ext;
                            over = r_range && (smp >= OVER_LIMIT);
                            trip = over && (r_trip[TRIP_ANODE] == '0);
                            n_trip[TRIP_ANODE] = f_trip_next(r_trip[TRIP_ANODE], over);
                            if (trip) begin
                                n_a_tgt  = '0;
                                n_s_tgt  = '0;
                                a_base   = '0;
                                n_s_duty = '0;
                                n_fault[FLT_ANODE] = 1'b1;
                            end
                            n_a_duty = f_slew(a_base, n_a_tgt);
                            // auto range: up on a high reading, down on a low one unless an anode fault is set
                            if (!r_range && (smp > RANGE_UP))
                                n_range = 1'b1;
                            if (!n_fault[FLT_ANODE] && n_range && (smp < RANGE_DOWN))
                                n_range = 1'b0;
                        end
                        SLOT_SVOLT: begin
                            n_running[SUM_SVOLT] = r_running[SUM_SVOLT] + smp_ext;
                        end
                        SLOT_SCUR: begin
                            n_running[SUM_SCUR] = r_running[SUM_SCUR] + smp_ext;
                            over = smp >= OVER_LIMIT;
                            trip = over && (r_trip[TRIP_SCREEN] == '0);
                            n_trip[TRIP_SCREEN] = f_trip_next(r_trip[TRIP_SCREEN], over);
                            n_s_duty = f_slew(trip ? '0 : r_s_duty, trip ? '0 : r_s_tgt);
                            if (trip) begin
                                n_s_tgt = '0;
                                n_fault[FLT_SCREEN] = 1'b1;
                            end
                        end
                        SLOT_GRID: begin
                            n_running[SUM_GRID] = r_running[SUM_GRID] + smp_ext;
                            // block end: latch, clear, temperature check
                            if (r_round == ROUND_W'(ROUNDS_PER_BLOCK)) begin
                                n_latched = n_running;
                                n_running = '{default: '0};
                                n_round   = '0;
                                done      = 1'b1;
                                if (n_latched[SUM_TEMP] > r_hi_temp)
                                    n_fault[FLT_TEMP] = 1'b1;
                                if (n_latched[SUM_TEMP] < r_lo_temp)
                                    n_fault[FLT_TEMP] = 1'b0;
                            end else begin
                                n_round = r_round + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        n_s1.rsp.grid_reset   = grid;
        n_s1.rsp.anode_drive  = n_a_duty;
        n_s1.rsp.screen_drive = n_s_duty;
        n_s1.rsp.heater_drive = '0;
        n_s1.rsp.high_range   = n_range;
        n_s1.rsp.error_flags  = n_fault;
        n_s1.rsp.block_done   = done;
        n_s1.rsp.read_value   = readv;
        n_s1.hv_tgt           = n_hv_tgt;
        n_s1.hc_tgt           = n_hc_tgt;
        n_s1.uh               = n_latched[SUM_HVOLT];
        n_s1.ih               = n_latched[SUM_HCUR];
        n_s1.ih_gt_min        = n_latched[SUM_HCUR] > IH_MIN;
    end

    // Config writes take priority; the user sees that items and writes never overlap, unchecked by the block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_thr <= '1;
            r_hv_tgt   <= '0;
            r_hc_tgt   <= '0;
            r_a_tgt    <= '0;
            r_s_tgt    <= '0;
            r_ref      <= '0;
            r_hi_temp  <= '1;
            r_lo_temp  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRID_THR: r_grid_thr <= i_cfg_data[SAMP_W-1:0];
                CFG_HV_TGT:   r_hv_tgt   <= i_cfg_data[HEAT_W-1:0];
                CFG_HC_TGT:   r_hc_tgt   <= i_cfg_data[HEAT_W-1:0];
                CFG_A_TGT:    r_a_tgt    <= i_cfg_data[DUTY_W-1:0];
                CFG_S_TGT:    r_s_tgt    <= i_cfg_data[DUTY_W-1:0];
                CFG_REF:      r_ref      <= i_cfg_data;
                CFG_HI_TEMP:  r_hi_temp  <= i_cfg_data;
                CFG_LO_TEMP:  r_lo_temp  <= i_cfg_data;
                default: ;
            endcase
        end else begin
            r_hv_tgt <= n_hv_tgt;
            r_hc_tgt <= n_hc_tgt;
            r_a_tgt  <= n_a_tgt;
            r_s_tgt  <= n_s_tgt;
        end
    end

    // Scan state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '{default: '0};
            r_latched <= '{default: '0};
            r_round   <= '0;
            r_trip    <= '{default: '0};
            r_a_duty  <= '0;
            r_s_duty  <= '0;
            r_range   <= 1'b0;
            r_fault   <= '0;
        end else begin
            r_running <= n_running;
            r_latched <= n_latched;
            r_round   <= n_round;
            r_trip    <= n_trip;
            r_a_duty  <= n_a_duty;
            r_s_duty  <= n_s_duty;
            r_range   <= n_range;
            r_fault   <= n_fault;
        end
    end

    // Stage register toward the heater pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_s1_valid <= 1'b0;
        else if (o_in_ready)
            r_s1_valid <= i_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept)
            r_s1 <= n_s1;
    end

    assign o_s1_valid  = r_s1_valid;
    assign o_s1        = r_s1;
    assign o_ref_scale = r_ref;

endmodule

>>> rtl/adc_ssr_heater.sv
// Heater regulation pipeline: scaled products, divide by ten, duty step,
// and the result register. Depends on adc_ssr_pkg.
`timescale 1ns / 1ps

module adc_ssr_heater import adc_ssr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s1_valid,
    input  t_stage           i_s1,
    output logic             o_s1_ready,
    input  logic [SUM_W-1:0] i_ref_scale,
    output logic             o_out_valid,
    output t_out_rsp         o_out_rsp,
    input  logic             i_out_ready
);

    logic              r_s2_valid, r_s3_valid, r_out_valid;
    t_stage            r_s2, r_s3;
    logic [PROD_W-1:0] r_pv, r_pc;
    logic [QUO_W-1:0]  r_q;
    logic [CUR_W-1:0]  r_c;
    t_out_rsp          r_out, n_out;
    logic [HEAT_W-1:0] r_heater, n_heater;
    logic [QUO_W-1:0]  n_q;
    logic              w_out_en, w_s3_en, w_s2_en;

    // Each stage moves when the one after it is empty or moving
    assign w_out_en   = !r_out_valid || i_out_ready;
    assign w_s3_en    = !r_s3_valid || w_out_en;
    assign w_s2_en    = !r_s2_valid || w_s3_en;
    assign o_s1_ready = w_s2_en;

    // Voltage difference and multiply-by-reciprocal for the divide by ten
    always_comb begin
        logic [DIFF_W-1:0]  pv_sh;
        logic [DIFF_W-1:0]  pc_sh;
        logic [DIFF_W-1:0]  diff;
        logic [QPROD_W-1:0] qprod;
        pv_sh = r_pv[PROD_W-1:V_SHIFT];
        pc_sh = {{(DIFF_W-(PROD_W-CV_SHIFT)){1'b0}}, r_pc[PROD_W-1:CV_SHIFT]};
        diff  = (pv_sh > pc_sh) ? (pv_sh - pc_sh) : '0;
        qprod = QPROD_W'(diff) * QPROD_W'(DIV10_MUL);
        n_q   = qprod[QPROD_W-1:DIV10_SHIFT];
    end

    // Heater duty step at block end: voltage mode first, then current mode
    always_comb begin
        logic [HEAT_W-1:0] d;
        logic [QUO_W-1:0]  hv_ext;
        logic [CUR_W-1:0]  hc_ext;
        d      = r_heater;
        hv_ext = {{(QUO_W-HEAT_W){1'b0}}, r_s3.hv_tgt};
        hc_ext = {{(CUR_W-HEAT_W){1'b0}}, r_s3.hc_tgt};
        if (r_s3.rsp.block_done) begin
            if ((r_s3.hv_tgt == '0) && (r_s3.hc_tgt == '0)) begin
                d = '0;
            end else begin
                if (r_s3.hv_tgt != '0) begin
                    if ((hv_ext > r_q) && (d != HEAT_MAX))
                        d = d + 1'b1;
                    if ((hv_ext < r_q) && (d != '0))
                        d = d - 1'b1;
                end
                if (r_s3.hc_tgt != '0) begin
                    if (hc_ext > r_c) begin
                        if ((d < HEAT_LOW_STEP) || (r_s3.ih_gt_min && (d != HEAT_MAX)))
                            d = d + 1'b1;
                    end
                    if ((hc_ext < r_c) && (d != '0))
                        d = d - 1'b1;
                end
            end
        end
        n_heater = d;
        // response with the updated heater duty
        n_out              = r_s3.rsp;
        n_out.heater_drive = d;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s2_en)
                r_s2_valid <= i_s1_valid;
            if (w_s3_en)
                r_s3_valid <= r_s2_valid;
            if (w_out_en)
                r_out_valid <= r_s3_valid;
        end
    end

    // Heater duty state, updated as a request enters the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_heater <= '0;
        else if (w_out_en && r_s3_valid)
            r_heater <= n_heater;
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_s2_en && i_s1_valid) begin
            r_s2 <= i_s1;
            r_pv <= PROD_W'(i_s1.uh) * PROD_W'(i_ref_scale);
            r_pc <= PROD_W'(i_s1.ih) * PROD_W'(i_ref_scale);
        end
        if (w_s3_en && r_s2_valid) begin
            r_s3 <= r_s2;
            r_q  <= n_q;
            r_c  <= r_pc[PROD_W-1:CI_SHIFT];
        end
        if (w_out_en && r_s3_valid)
            r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

>>> rtl/adc_scan_supervisor_regulator.sv
// ADC scan supervisor and regulator, top level.
// Instantiates adc_ssr_front and adc_ssr_heater; types from adc_ssr_pkg.
//
//  Port group   Direction  Handshake            Payload
//  ----------   ---------  -------------------  ---------------------------
//  in           request    i_in_valid/o_in_ready   t_in_req  (i_in_req)
//  out          response   o_out_valid/i_out_ready t_out_rsp (o_out_rsp)
//  cfg          write      i_cfg_we                i_cfg_idx, i_cfg_data
//
// One request per cycle sustained while the response side does not stall;
// the front stage does the whole state update for a request combinationally.
// A response passes the front stage register, the heater registers s2 and s3
// (products, then the divide by ten) and then the result register. Synchronous
// reset clears all sums and duties at once. A stall on the response side backs
// up stage by stage; requests are taken while any stage holds a bubble.
`timescale 1ns / 1ps

module adc_scan_supervisor_regulator import adc_ssr_pkg::*; #(
    parameter int unsigned ROUNDS_PER_BLOCK = ROUNDS_DEF,
    parameter int unsigned TRIP_COUNT       = TRIP_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_req              i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_rsp             o_out_rsp
);

    logic             w_s1_valid;
    t_stage           w_s1;
    logic             w_s2_ready;
    logic [SUM_W-1:0] w_ref_scale;

    adc_ssr_front #(
        .ROUNDS_PER_BLOCK (ROUNDS_PER_BLOCK),
        .TRIP_COUNT       (TRIP_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_s1_valid  (w_s1_valid),
        .o_s1        (w_s1),
        .i_s2_ready  (w_s2_ready),
        .o_ref_scale (w_ref_scale)
    );

    adc_ssr_heater u_heater (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (w_s1_valid),
        .i_s1        (w_s1),
        .o_s1_ready  (w_s2_ready),
        .i_ref_scale (w_ref_scale),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp),
        .i_out_ready (i_out_ready)
    );

    // No response left over from before reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("response valid right after reset");

    // Input only blocks when the whole pipeline is full and stalled
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("request refused while pipeline has room");

    // An accepted request always lands in the front stage register
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> w_s1_valid)
        else $error("accepted request lost");

    // A sum readback never comes with a block end or grid pulse
    a_read_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_rsp.read_value != '0))
        |-> (!o_out_rsp.block_done && !o_out_rsp.grid_reset))
        else $error("readback mixed with sample results");

endmodule

>>> tb/sv/adc_ssr_status_check.sv
// Response checker for the ADC scan supervisor and regulator.
// Tracks the supervisor state from accepted requests and register writes,
// then compares every accepted response against it. Types from adc_ssr_pkg.
`timescale 1ns / 1ps

module adc_ssr_status_check import adc_ssr_pkg::*; #(
    parameter int unsigned ROUNDS_PER_BLOCK = ROUNDS_DEF,
    parameter int unsigned TRIP_COUNT       = TRIP_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in_req              i_in_req,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out_rsp             i_out_rsp,
    output int                   o_status_due,
    output int                   o_mismatch_cnt
);

    localparam int unsigned VOLT_DIV  = 10;
    localparam int          MAX_SHOWN = 10;

    // Register copies
    logic [SAMP_W-1:0]  grid_thr;
    logic [HEAT_W-1:0]  hv_tgt;
    logic [HEAT_W-1:0]  hc_tgt;
    logic [DUTY_W-1:0]  a_tgt;
    logic [DUTY_W-1:0]  s_tgt;
    logic [SUM_W-1:0]   ref_scale;
    logic [SUM_W-1:0]   hi_temp;
    logic [SUM_W-1:0]   lo_temp;

    // Supervisor state
    logic [SUM_W-1:0]   run_sum [SUM_N];
    logic [SUM_W-1:0]   lat_sum [SUM_N];
    logic [ROUND_W-1:0] rounds;
    logic [TRIP_W-1:0]  trip_cnt [TRIP_N];
    logic [DUTY_W-1:0]  a_duty;
    logic [DUTY_W-1:0]  s_duty;
    logic [HEAT_W-1:0]  h_duty;
    logic               hi_range;
    logic [FAULT_W-1:0] faults;

    // Status words owed by the block, oldest first
    t_out_rsp scan_status_q [$];
    int       mismatches = 0;
    int       owed = 0;

    assign o_status_due   = owed;
    assign o_mismatch_cnt = mismatches;

    function automatic void clear_state();
        grid_thr  = '1;
        hv_tgt    = '0;
        hc_tgt    = '0;
        a_tgt     = '0;
        s_tgt     = '0;
        ref_scale = '0;
        hi_temp   = '1;
        lo_temp   = '0;
        for (int i = 0; i < SUM_N; i++) begin
            run_sum[i] = '0;
            lat_sum[i] = '0;
        end
        for (int i = 0; i < TRIP_N; i++) begin
            trip_cnt[i] = '0;
        end
        rounds   = '0;
        a_duty   = '0;
        s_duty   = '0;
        h_duty   = '0;
        hi_range = 1'b0;
        faults   = '0;
    endfunction

    function automatic void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DAT_W-1:0] data);
        case (idx)
            CFG_GRID_THR: grid_thr  = data[SAMP_W-1:0];
            CFG_HV_TGT:   hv_tgt    = data[HEAT_W-1:0];
            CFG_HC_TGT:   hc_tgt    = data[HEAT_W-1:0];
            CFG_A_TGT:    a_tgt     = data[DUTY_W-1:0];
            CFG_S_TGT:    s_tgt     = data[DUTY_W-1:0];
            CFG_REF:      ref_scale = data;
            CFG_HI_TEMP:  hi_temp   = data;
            CFG_LO_TEMP:  lo_temp   = data;
            default: ;
        endcase
    endfunction

    // One step of a drive duty toward its target
    function automatic logic [DUTY_W-1:0] slew_toward(input logic [DUTY_W-1:0] duty,
                                                      input logic [DUTY_W-1:0] tgt);
        if (duty < tgt) return duty + 1'b1;
        if (duty > tgt) return duty - 1'b1;
        return duty;
    endfunction

    // Over-limit run counter; returns 1 when the count was already used up
    function automatic logic trip_step(input int idx, input logic over);
        if (!over) begin
            trip_cnt[idx] = TRIP_W'(TRIP_COUNT);
            return 1'b0;
        end
        if (trip_cnt[idx] != '0) begin
            trip_cnt[idx] = trip_cnt[idx] - 1'b1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Heater duty step from the freshly latched sums
    function automatic void regulate_heater();
        int unsigned uh, ih, volts, drop, amps;
        uh = lat_sum[SUM_HVOLT];
        ih = lat_sum[SUM_HCUR];
        if (hv_tgt == '0 && hc_tgt == '0) begin
            h_duty = '0;
            return;
        end
        // voltage mode: scaled heater voltage minus the sense drop, in 0.1 V
        if (hv_tgt != '0) begin
            volts = (uh * ref_scale) >> V_SHIFT;
            drop  = (ih * ref_scale) >> CV_SHIFT;
            volts = (volts > drop) ? volts - drop : 0;
            volts = volts / VOLT_DIV;
            if (hv_tgt > volts && h_duty < HEAT_MAX) h_duty = h_duty + 1'b1;
            if (hv_tgt < volts && h_duty > 0) h_duty = h_duty - 1'b1;
        end
        // current mode runs after voltage mode
        if (hc_tgt != '0) begin
            amps = (ih * ref_scale) >> CI_SHIFT;
            if (hc_tgt > amps) begin
                if (h_duty < HEAT_LOW_STEP || (ih > IH_MIN && h_duty < HEAT_MAX))
                    h_duty = h_duty + 1'b1;
            end
            if (hc_tgt < amps && h_duty > 0) h_duty = h_duty - 1'b1;
        end
    endfunction

    // Applies one request to the state and returns the status it produces
    function automatic t_out_rsp advance_scan(input t_in_req req);
        t_out_rsp st;
        logic [SUM_W-1:0] samp;
        st   = '0;
        samp = SUM_W'(req.sample);
        case (req.mode)
            MODE_CLEAR: faults = '0;
            MODE_READ:  st.read_value = lat_sum[req.sum_index];
            MODE_SAMPLE: begin
                if (req.channel >= GRID_FIRST && req.channel <= GRID_LAST &&
                    req.sample >= grid_thr)
                    st.grid_reset = 1'b1;
                case (req.channel)
                    SLOT_TEMP:  run_sum[SUM_TEMP]  = run_sum[SUM_TEMP] + samp;
                    SLOT_HVOLT: run_sum[SUM_HVOLT] = run_sum[SUM_HVOLT] + samp;
                    SLOT_AVOLT: run_sum[SUM_AVOLT] = run_sum[SUM_AVOLT] + samp;
                    SLOT_SVOLT: run_sum[SUM_SVOLT] = run_sum[SUM_SVOLT] + samp;
                    SLOT_HCUR: begin
                        run_sum[SUM_HCUR] = run_sum[SUM_HCUR] + samp;
                        if (trip_step(TRIP_HEAT, req.sample > HCUR_LIMIT)) begin
                            hv_tgt = '0;
                            hc_tgt = '0;
                            faults[FLT_HEAT] = 1'b1;
                        end
                    end
                    SLOT_ACUR: begin
                        run_sum[SUM_ACUR] = run_sum[SUM_ACUR] + samp;
                        // over-limit only counts on the high range
                        if (trip_step(TRIP_ANODE, hi_range && req.sample >= OVER_LIMIT)) begin
                            a_tgt  = '0;
                            s_tgt  = '0;
                            a_duty = '0;
                            s_duty = '0;
                            faults[FLT_ANODE] = 1'b1;
                        end
                        a_duty = slew_toward(a_duty, a_tgt);
                        if (!hi_range && req.sample > RANGE_UP) hi_range = 1'b1;
                        // an anode fault pins the meter on the high range
                        if (!faults[FLT_ANODE] && hi_range && req.sample < RANGE_DOWN)
                            hi_range = 1'b0;
                    end
                    SLOT_SCUR: begin
                        run_sum[SUM_SCUR] = run_sum[SUM_SCUR] + samp;
                        if (trip_step(TRIP_SCREEN, req.sample >= OVER_LIMIT)) begin
                            s_tgt  = '0;
                            s_duty = '0;
                            faults[FLT_SCREEN] = 1'b1;
                        end
                        s_duty = slew_toward(s_duty, s_tgt);
                    end
                    SLOT_GRID: begin
                        run_sum[SUM_GRID] = run_sum[SUM_GRID] + samp;
                        if (rounds == ROUND_W'(ROUNDS_PER_BLOCK)) begin
                            // block end: latch, clear, regulate, check temperature
                            for (int i = 0; i < SUM_N; i++) begin
                                lat_sum[i] = run_sum[i];
                                run_sum[i] = '0;
                            end
                            rounds        = '0;
                            st.block_done = 1'b1;
                            regulate_heater();
                            if (lat_sum[SUM_TEMP] > hi_temp) faults[FLT_TEMP] = 1'b1;
                            if (lat_sum[SUM_TEMP] < lo_temp) faults[FLT_TEMP] = 1'b0;
                        end else begin
                            rounds = rounds + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        st.anode_drive  = a_duty;
        st.screen_drive = s_duty;
        st.heater_drive = h_duty;
        st.high_range   = hi_range;
        st.error_flags  = faults;
        return st;
    endfunction

    function automatic string show_status(input t_out_rsp st);
        return $sformatf("grid=%0d anode=%0d screen=%0d heat=%0d hr=%0d err=%h done=%0d rd=%0d",
                         st.grid_reset, st.anode_drive, st.screen_drive, st.heater_drive,
                         st.high_range, st.error_flags, st.block_done, st.read_value);
    endfunction

    // Sample both channels at the rising edge; responses are matched first,
    // since a request accepted on this edge cannot answer on the same edge
    always @(posedge i_clk) begin
        t_out_rsp want;
        if (!i_rst_n) begin
            clear_state();
            scan_status_q.delete();
        end else begin
            if (i_cfg_we) write_reg(i_cfg_idx, i_cfg_data);
            if (i_out_valid && i_out_ready) begin
                if (scan_status_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("%0t: response with no request pending: %s",
                                 $realtime, show_status(i_out_rsp));
                end else begin
                    want = scan_status_q.pop_front();
                    // packed compare covers every field, X included
                    if (i_out_rsp !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN) begin
                            $display("%0t: status mismatch", $realtime);
                            $display("  exp %s", show_status(want));
                            $display("  got %s", show_status(i_out_rsp));
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                scan_status_q.push_back(advance_scan(i_in_req));
        end
        owed = scan_status_q.size();
    end

endmodule

>>> tb/sv/adc_scan_supervisor_regulator_test.sv
// Testbench top for adc_scan_supervisor_regulator: clock, reset, request and
// register stimulus, response back-pressure and the verdict.
// Depends on adc_ssr_pkg, the block, and adc_ssr_status_check.
`timescale 1ns / 1ps

module adc_scan_supervisor_regulator_test;
    import adc_ssr_pkg::*;

    localparam int CYCLE_LIMIT = 800_000;
    localparam int LONG_HOLD   = 120;
    localparam int HOLD_AT     = 300;
    localparam int PHASE_ITEMS = 120;
    localparam int N_PHASES    = 6;
    localparam int SETTLE      = 8;
    localparam int TRIP_RUN    = 18;
    localparam int HEAVY_RUN   = 70;

    // Codes the package does not name
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic [CHAN_W-1:0] SLOT_SPARE = 4'd2;
    localparam logic [CHAN_W-1:0] SLOT_PAD_A = 4'd14;
    localparam logic [CHAN_W-1:0] SLOT_PAD_B = 4'd15;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_req              i_in_req;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_rsp             o_out_rsp;

    int status_due;
    int mismatch_cnt;
    int sent_cnt  = 0;
    int cycle_cnt = 0;
    int calm_left = 0;

    adc_scan_supervisor_regulator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    adc_ssr_status_check i_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_in_req       (i_in_req),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_out_rsp      (o_out_rsp),
        .o_status_due   (status_due),
        .o_mismatch_cnt (mismatch_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SAMP_W-1:0] any_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return SAMP_W'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [SEL_W-1:0] any_sel();
        return SEL_W'($urandom);
    endfunction

    function automatic t_in_req mk_req(input logic [MODE_W-1:0] mode,
                                       input logic [CHAN_W-1:0] chan,
                                       input logic [SAMP_W-1:0] samp,
                                       input logic [SEL_W-1:0]  sel);
        t_in_req r;
        r.mode      = mode;
        r.channel   = chan;
        r.sample    = samp;
        r.sum_index = sel;
        return r;
    endfunction

    // Offer one request after a random gap and hold it until taken
    task automatic send_req(input t_in_req req);
        int gap;
        if (calm_left > 0) begin
            calm_left--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(20, 60);
            gap = idle_len();
        end
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do @(posedge i_clk); while (!o_in_ready);
        sent_cnt++;
    endtask

    // Stop offering and wait until every response is back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (status_due != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DAT_W'(val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic load_regs(input int unsigned grid, input int unsigned hv,
                             input int unsigned hc, input int unsigned anode,
                             input int unsigned screen, input int unsigned scale,
                             input int unsigned hi, input int unsigned lo);
        write_reg(CFG_GRID_THR, grid);
        write_reg(CFG_HV_TGT, hv);
        write_reg(CFG_HC_TGT, hc);
        write_reg(CFG_A_TGT, anode);
        write_reg(CFG_S_TGT, screen);
        write_reg(CFG_REF, scale);
        write_reg(CFG_HI_TEMP, hi);
        write_reg(CFG_LO_TEMP, lo);
    endtask

    // One random burst of requests
    task automatic run_scan();
        int kind, k, n;
        logic [CHAN_W-1:0] ch;
        logic [SAMP_W-1:0] s;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            // grid slot only: walks the round count toward block end
            n = $urandom_range(1, 8);
            repeat (n) send_req(mk_req(MODE_SAMPLE, SLOT_GRID, any_sample(), any_sel()));
        end else if (kind < 70) begin
            // the slots that feed heater regulation and temperature, plus now and then a read
            send_req(mk_req(MODE_SAMPLE, SLOT_TEMP, any_sample(), any_sel()));
            s = ($urandom_range(0, 9) == 0) ? SAMP_W'($urandom_range(401, 1023))
                                            : SAMP_W'($urandom_range(0, 400));
            send_req(mk_req(MODE_SAMPLE, SLOT_HCUR, s, any_sel()));
            send_req(mk_req(MODE_SAMPLE, SLOT_HVOLT, any_sample(), any_sel()));
            send_req(mk_req(MODE_SAMPLE, SLOT_GRID, any_sample(), any_sel()));
            if ($urandom_range(0, 3) == 0)
                send_req(mk_req(MODE_READ, CHAN_W'($urandom), any_sample(), any_sel()));
        end else if (kind < 85) begin
            // full scan, unused slots included
            for (k = 0; k < 16; k++)
                send_req(mk_req(MODE_SAMPLE, CHAN_W'(k), any_sample(), any_sel()));
        end else if (kind < 95) begin
            // noise: any mode, any slot
            n = $urandom_range(1, 3);
            repeat (n) send_req(mk_req(MODE_W'($urandom), CHAN_W'($urandom),
                                       SAMP_W'($urandom), any_sel()));
        end else if (kind < 98) begin
            // over-limit run long enough to use up a trip counter
            case ($urandom_range(0, 2))
                0:       ch = SLOT_HCUR;
                1:       ch = SLOT_ACUR;
                default: ch = SLOT_SCUR;
            endcase
            for (k = 0; k < TRIP_RUN; k++) begin
                if ($urandom_range(0, 29) == 0)
                    s = SAMP_W'($urandom_range(0, 84));
                else if (ch == SLOT_HCUR)
                    s = SAMP_W'($urandom_range(401, 1023));
                else
                    s = SAMP_W'($urandom_range(1020, 1023));
                send_req(mk_req(MODE_SAMPLE, ch, s, any_sel()));
            end
        end else begin
            // heavy run on one summed slot so its running sum wraps
            case ($urandom_range(0, 3))
                0:       ch = SLOT_TEMP;
                1:       ch = SLOT_HVOLT;
                2:       ch = SLOT_AVOLT;
                default: ch = SLOT_SVOLT;
            endcase
            repeat (HEAVY_RUN)
                send_req(mk_req(MODE_SAMPLE, ch, SAMP_W'($urandom_range(1000, 1023)),
                                any_sel()));
        end
    endtask

    // Response side: random stalls, one long hold-off to back the block up
    initial begin : out_side
        int run_len, stall_len;
        bit held;
        i_out_ready = 1'b0;
        held        = 1'b0;
        forever begin
            if (!held && sent_cnt >= HOLD_AT) begin
                held = 1'b1;
                for (int c = 0; c < LONG_HOLD; c++) begin
                    @(negedge i_clk);
                    i_out_ready <= 1'b0;
                end
            end
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(1, 6);
            repeat (run_len) begin
                @(negedge i_clk);
                i_out_ready <= 1'b1;
            end
            stall_len = idle_len();
            repeat (stall_len) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Request side and verdict
    initial begin : in_side
        int ph, base;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_req   = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests on reset register values (grid threshold at top)
        // heater trip on the first over-limit sample, counters start empty
        send_req(mk_req(MODE_SAMPLE, SLOT_HCUR, 10'd1023, '0));
        send_req(mk_req(MODE_SAMPLE, SLOT_HCUR, 10'd400, '1));
        send_req(mk_req(MODE_SAMPLE, SLOT_HCUR, 10'd401, '0));
        send_req(mk_req(MODE_SAMPLE, SLOT_TEMP, 10'd1023, '0));
        send_req(mk_req(MODE_SAMPLE, SLOT_HVOLT, 10'd1023, '0));
        send_req(mk_req(MODE_SAMPLE, SLOT_AVOLT, 10'd0, '1));
        send_req(mk_req(MODE_SAMPLE, SLOT_SVOLT, 10'd1023, '0));
        // range up, anode trip, range held by the fault, then released
        send_req(mk_req(MODE_SAMPLE, SLOT_ACUR, 10'd951, '0));
        send_req(mk_req(MODE_SAMPLE, SLOT_ACUR, 10'd1020, '0));
        send_req(mk_req(MODE_SAMPLE, SLOT_ACUR, 10'd84, '0));
        send_req(mk_req(MODE_CLEAR, SLOT_PAD_B, 10'd1023, '1));
        send_req(mk_req(MODE_SAMPLE, SLOT_ACUR, 10'd84, '0));
        send_req(mk_req(MODE_SAMPLE, SLOT_ACUR, 10'd950, '0));
        // screen trip and reload
        send_req(mk_req(MODE_SAMPLE, SLOT_SCUR, 10'd1020, '0));
        send_req(mk_req(MODE_SAMPLE, SLOT_SCUR, 10'd1019, '0));
        // grid pulse window edges and unused slots
        send_req(mk_req(MODE_SAMPLE, SLOT_SPARE, 10'd1023, '0));
        send_req(mk_req(MODE_SAMPLE, GRID_LAST, 10'd1022, '0));
        send_req(mk_req(MODE_SAMPLE, SLOT_GRID, 10'd1023, '0));
        send_req(mk_req(MODE_SAMPLE, SLOT_PAD_A, 10'd1023, '0));
        send_req(mk_req(MODE_SAMPLE, SLOT_PAD_B, 10'd0, '0));
        // unused mode, reads before any block end, clear
        send_req(mk_req(MODE_SPARE, SLOT_PAD_B, 10'd1023, '1));
        send_req(mk_req(MODE_READ, SLOT_TEMP, 10'd0, SUM_TEMP));
        send_req(mk_req(MODE_READ, SLOT_TEMP, 10'd0, SUM_GRID));
        send_req(mk_req(MODE_CLEAR, SLOT_TEMP, 10'd0, '0));

        // Random phases, registers rewritten while the block is idle
        for (ph = 0; ph < N_PHASES; ph++) begin
            drain();
            case (ph)
                0: load_regs(0, 0, 0, 1023, 1023, 65535, 65535, 0);
                1: load_regs(1023, 200, 0, 0, 0, 0, 0, 65535);
                2: load_regs($urandom_range(0, 1023), $urandom_range(1, 200), 0,
                             $urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom_range(0, 3000), $urandom_range(0, 30000), 0);
                3: load_regs($urandom_range(0, 1023), 0, $urandom_range(1, 250),
                             $urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom_range(0, 3000), 65535, $urandom_range(0, 20000));
                4: load_regs(1, 1, 250, 1, 1, 65535, 1, 65534);
                default: begin
                    base = $urandom_range(0, 30000);
                    load_regs($urandom_range(0, 1023), $urandom_range(1, 200),
                              $urandom_range(1, 250), $urandom_range(0, 1023),
                              $urandom_range(0, 1023), $urandom_range(0, 3000),
                              base, $urandom_range(0, base));
                end
            endcase
            base = sent_cnt;
            while (sent_cnt - base < PHASE_ITEMS) run_scan();
        end

        drain();
        repeat (SETTLE) @(negedge i_clk);
        if (mismatch_cnt == 0 && status_due == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
